/* hw/rtl/icq_pkg.sv */
// Shared types and codes for the indexed completion queue.
`timescale 1ns / 1ps

package icq_pkg;

	localparam int IDX_W    = 63;
	localparam int HPORT_W  = 32;

	typedef enum logic [1:0] {
		CMD_APPEND   = 2'd0,
		CMD_POP      = 2'd1,
		CMD_CLEAR    = 2'd2,
		CMD_SET_BASE = 2'd3
	} icq_cmd_t;

	typedef enum logic [1:0] {
		KIND_DONE  = 2'd0,
		KIND_ABORT = 2'd1,
		KIND_ACK   = 2'd2
	} icq_kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BEYOND    = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_EMPTY = 2'd3
	} icq_status_t;

	// Control of one storage cell.
	typedef struct packed {
		logic shift;
		logic write;
	} icq_cell_ctl_t;

endpackage

/* hw/rtl/icq_cell.sv */
// One storage cell of the queue chain: load an item or take the neighbor's entry.
`timescale 1ns / 1ps

module icq_cell import icq_pkg::*; #(
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  icq_cell_ctl_t     ctl,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [DATA_W-1:0] next_data,
	output logic [DATA_W-1:0] data
);

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			data_q <= next_data;
		end else if (ctl.write) begin
			data_q <= wr_data;
		end
	end

	assign data = data_q;

endmodule

/* hw/rtl/indexed_completion_queue_unit.sv */
// Top level of the indexed completion queue: command sequencer and cell chain.
//
//  channel   | handshake             | fields
//  ----------+-----------------------+------------------------------------------------
//  command   | start, busy           | command, handle, log_index
//  result    | result_valid (strobe) | item_kind, out_handle, head_index, status, last
//
// An item is taken when start is high and busy is low; busy stays high until its
// acknowledge is on the result ports. Append, set-base, a pop with nothing to release
// and a clear of an empty queue are acknowledged straight from decode. A pop that
// releases N entries, or a clear of N entries (null or not), shifts all N out before its acknowledge.
// The cell chain shifts one entry toward the head per cycle, which sets the drain rate.
// Reset empties the queue and zeroes the base index; cells hold no reset.
// Results are strobed for one cycle each and cannot be stalled.
`timescale 1ns / 1ps

module indexed_completion_queue_unit import icq_pkg::*; #(
	parameter int QUEUE_DEPTH = 32,
	parameter int HANDLE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [HPORT_W-1:0] handle,
	input  logic [IDX_W-1:0]   log_index,
	output logic               result_valid,
	output logic [1:0]         item_kind,
	output logic [HPORT_W-1:0] out_handle,
	output logic [IDX_W-1:0]   head_index,
	output logic [1:0]         status,
	output logic               last
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_DRAIN,
		S_FLUSH,
		S_ACK
	} state_t;

	state_t             state_q;
	icq_cmd_t           cmd_q;
	logic [HPORT_W-1:0] handle_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   base_q;
	logic [IDX_W-1:0]   first_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   remain_q;

	logic               res_valid_q;
	icq_kind_t          kind_q;
	logic [HPORT_W-1:0] res_handle_q;
	logic [IDX_W-1:0]   res_first_q;
	icq_status_t        status_q;
	logic               last_q;

	logic [HANDLE_BITS-1:0] chain [QUEUE_DEPTH+1];
	logic [HANDLE_BITS-1:0] wr_data;
	logic [63:0]            handle_wide;
	logic [63:0]            head_wide;
	logic [HPORT_W-1:0]     head_handle;
	logic                   full;
	logic                   lt_base;
	logic [IDX_W-1:0]       diff;
	logic                   in_range;
	logic                   do_write;
	logic                   do_shift;

	assign handle_wide = 64'(handle_q);
	assign wr_data     = handle_wide[HANDLE_BITS-1:0];
	assign head_wide   = 64'(chain[0]);
	assign head_handle = head_wide[HPORT_W-1:0];

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign lt_base  = (idx_q < base_q);
	assign diff     = idx_q - base_q;
	assign in_range = !lt_base && (diff < IDX_W'(count_q));

	assign do_write = (state_q == S_DECODE) && (cmd_q == CMD_APPEND) && !full;
	assign do_shift = (state_q == S_DRAIN) || (state_q == S_FLUSH);

	assign chain[QUEUE_DEPTH] = '0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		icq_cell_ctl_t ctl;
		assign ctl.shift = do_shift;
		assign ctl.write = do_write && (count_q == CNT_W'(i));
		icq_cell #(
			.DATA_W(HANDLE_BITS)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.wr_data  (wr_data),
			.next_data(chain[i+1]),
			.data     (chain[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			base_q       <= '0;
			res_valid_q  <= 1'b0;
			cmd_q        <= CMD_APPEND;
			handle_q     <= '0;
			idx_q        <= '0;
			first_q      <= '0;
			kind_q       <= KIND_ACK;
			res_handle_q <= '0;
			res_first_q  <= '0;
			status_q     <= ST_OK;
			last_q       <= 1'b0;
			remain_q     <= '0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q    <= icq_cmd_t'(command);
						handle_q <= handle;
						idx_q    <= log_index;
						state_q  <= S_DECODE;
					end
				end
				S_DECODE: begin
					// ack fields by default; drain paths override the state
					kind_q       <= KIND_ACK;
					res_handle_q <= '0;
					last_q       <= 1'b1;
					status_q     <= ST_OK;
					res_first_q  <= base_q;
					state_q      <= S_IDLE;
					case (cmd_q)
						CMD_APPEND: begin
							res_valid_q <= 1'b1;
							if (full) begin
								status_q <= ST_FULL;
							end else begin
								count_q <= count_q + CNT_W'(1);
							end
						end
						CMD_POP: begin
							if (count_q == '0 || lt_base) begin
								res_valid_q <= 1'b1;
								res_first_q <= idx_q + IDX_W'(1);
							end else if (!in_range) begin
								res_valid_q <= 1'b1;
								status_q    <= ST_BEYOND;
							end else begin
								first_q  <= base_q;
								remain_q <= diff[CNT_W-1:0] + CNT_W'(1);
								state_q  <= S_DRAIN;
							end
						end
						CMD_CLEAR: begin
							first_q <= '0;
							if (count_q == '0) begin
								res_valid_q <= 1'b1;
								res_first_q <= '0;
								base_q      <= '0;
							end else begin
								state_q <= S_FLUSH;
							end
						end
						CMD_SET_BASE: begin
							res_valid_q <= 1'b1;
							if (count_q != '0) begin
								status_q <= ST_NOT_EMPTY;
							end else begin
								base_q      <= idx_q;
								res_first_q <= idx_q;
							end
						end
						default: begin
							res_valid_q <= 1'b1;
						end
					endcase
				end
				S_DRAIN: begin
					res_valid_q  <= 1'b1;
					kind_q       <= KIND_DONE;
					res_handle_q <= head_handle;
					res_first_q  <= first_q;
					status_q     <= ST_OK;
					last_q       <= 1'b0;
					count_q      <= count_q - CNT_W'(1);
					remain_q     <= remain_q - CNT_W'(1);
					if (remain_q == CNT_W'(1)) begin
						base_q  <= idx_q + IDX_W'(1);
						state_q <= S_ACK;
					end
				end
				S_FLUSH: begin
					// drop null entries silently
					res_valid_q  <= (head_handle != '0);
					kind_q       <= KIND_ABORT;
					res_handle_q <= head_handle;
					res_first_q  <= '0;
					status_q     <= ST_OK;
					last_q       <= 1'b0;
					count_q      <= count_q - CNT_W'(1);
					if (count_q == CNT_W'(1)) begin
						base_q  <= '0;
						state_q <= S_ACK;
					end
				end
				S_ACK: begin
					res_valid_q  <= 1'b1;
					kind_q       <= KIND_ACK;
					res_handle_q <= '0;
					res_first_q  <= first_q;
					status_q     <= ST_OK;
					last_q       <= 1'b1;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = res_valid_q;
	assign item_kind    = kind_q;
	assign out_handle   = res_handle_q;
	assign head_index   = res_first_q;
	assign status       = status_q;
	assign last         = last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count exceeds queue depth");

	a_last_is_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |-> (item_kind == KIND_ACK))
		else $error("final item of a command is not an acknowledge");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_DECODE))
		else $error("accepted item did not enter decode");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN || state_q == S_FLUSH) |-> (count_q != '0))
		else $error("release from an empty queue");

	a_ack_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |-> !busy)
		else $error("acknowledge issued while still busy");
`endif

endmodule
